FILE: design/acd_pkg.sv
// Package for the analog code detector: payload structs, register indexes,
// reset values and shared widths. No dependencies.
package acd_pkg;

  localparam int MAX_CH    = 5;
  localparam int RAW_W     = 10;
  localparam int THR_W     = 7;
  localparam int SETTLE_W  = 16;
  localparam int TIME_W    = 32;
  localparam int CODE_W    = 5;
  localparam int PROD_W    = 18;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  localparam int DEF_CHANNELS = 5;

  localparam logic [RAW_W-1:0] FS_OFFSET = 10'd20;
  localparam logic [RAW_W-1:0] FS_MIN    = 10'd21;
  localparam logic [6:0]       PERCENT   = 7'd100;

  localparam logic [THR_W-1:0]    LOW_RST    = 7'd20;
  localparam logic [THR_W-1:0]    HIGH_RST   = 7'd28;
  localparam logic [SETTLE_W-1:0] SETTLE_RST = 16'd200;
  localparam logic [RAW_W-1:0]    FS_RST [MAX_CH] = '{10'd950, 10'd910, 10'd885,
                                                      10'd900, 10'd895};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOW_THR  = 3'd0,
    REG_HIGH_THR = 3'd1,
    REG_SETTLE   = 3'd2,
    REG_FS_CH0   = 3'd3,
    REG_FS_CH1   = 3'd4,
    REG_FS_CH2   = 3'd5,
    REG_FS_CH3   = 3'd6,
    REG_FS_CH4   = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [RAW_W-1:0]  raw_ch0;
    logic [RAW_W-1:0]  raw_ch1;
    logic [RAW_W-1:0]  raw_ch2;
    logic [RAW_W-1:0]  raw_ch3;
    logic [RAW_W-1:0]  raw_ch4;
    logic [TIME_W-1:0] now_ms;
    logic              ignore_extremes;
  } in_item_t;

  typedef struct packed {
    logic              changed;
    logic [CODE_W-1:0] active_code_out;
    logic [CODE_W-1:0] mirror_code_out;
    logic [CODE_W-1:0] held_code_out;
  } out_item_t;

  // What one lane found for its sample.
  typedef struct packed {
    logic clr;
    logic set;
  } lane_flags_t;

endpackage

FILE: design/analog_code_detector_unit.sv
// Top level of the analog code detector: configuration registers, sequencer,
// channel lanes and output register. Uses acd_pkg, acd_lane and acd_merge.
//
// Usage. Each input transaction on in_data carries one 10-bit sample per
// channel, a free-running millisecond time and the ignore flag. Every input
// transaction produces exactly one output transaction on out_data with the
// changed flag and the active, mirror and held codes after that item.
// The block works on one item at a time. An accepted item passes through
// the lane multipliers, the lane compares and the merging update, the
// three steps of the lane and merge path; its result is written into the
// output register in the update step, and in_ready returns the cycle
// after that.
// If the receiver stalls, the finished result waits in the output register
// and the update step holds until it is taken, so nothing is lost.
// Configuration transactions on the cfg port are always accepted; they are
// to be written only while no item is in flight.
// Synchronous reset (rst_n low) returns the sequencer to idle, empties the
// output register, loads the register reset values and clears all codes
// and the stored change time.
module analog_code_detector_unit
  import acd_pkg::*;
#(
  parameter int CHANNELS = DEF_CHANNELS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_CMP  = 4'b0100,
    S_UPD  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [THR_W-1:0]    low_r,    low_nxt;
  logic [THR_W-1:0]    high_r,   high_nxt;
  logic [SETTLE_W-1:0] settle_r, settle_nxt;
  logic [RAW_W-1:0]    fs_r   [MAX_CH];
  logic [RAW_W-1:0]    fs_nxt [MAX_CH];

  in_item_t  item_r;
  out_item_t out_data_r;
  logic      out_valid_r, out_valid_nxt;

  logic [RAW_W-1:0] raw_a [MAX_CH];
  lane_flags_t      flags [CHANNELS];
  out_item_t        result;
  logic             accept;
  logic             upd_go;

  assign cfg_ready = 1'b1;
  assign in_ready  = state_r == S_IDLE;
  assign accept    = in_valid && in_ready;
  // The update step fires only when the output register can take the result.
  assign upd_go    = (state_r == S_UPD) && (!out_valid_r || out_ready);

  // Configuration register decode.
  always_comb begin
    low_nxt    = low_r;
    high_nxt   = high_r;
    settle_nxt = settle_r;
    fs_nxt     = fs_r;
    if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_LOW_THR:  low_nxt    = cfg_data[THR_W-1:0];
        REG_HIGH_THR: high_nxt   = cfg_data[THR_W-1:0];
        REG_SETTLE:   settle_nxt = cfg_data[SETTLE_W-1:0];
        REG_FS_CH0:   fs_nxt[0]  = cfg_data[RAW_W-1:0];
        REG_FS_CH1:   fs_nxt[1]  = cfg_data[RAW_W-1:0];
        REG_FS_CH2:   fs_nxt[2]  = cfg_data[RAW_W-1:0];
        REG_FS_CH3:   fs_nxt[3]  = cfg_data[RAW_W-1:0];
        REG_FS_CH4:   fs_nxt[4]  = cfg_data[RAW_W-1:0];
        default:      low_nxt    = low_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r    <= LOW_RST;
      high_r   <= HIGH_RST;
      settle_r <= SETTLE_RST;
      fs_r     <= FS_RST;
    end else begin
      low_r    <= low_nxt;
      high_r   <= high_nxt;
      settle_r <= settle_nxt;
      fs_r     <= fs_nxt;
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (accept) state_nxt = S_MUL;
      S_MUL:   state_nxt = S_CMP;
      S_CMP:   state_nxt = S_UPD;
      S_UPD:   if (upd_go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (upd_go) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // The item is held for the whole time it is in flight.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
    end
    if (upd_go) begin
      out_data_r <= result;
    end
  end

  assign raw_a[0] = item_r.raw_ch0;
  assign raw_a[1] = item_r.raw_ch1;
  assign raw_a[2] = item_r.raw_ch2;
  assign raw_a[3] = item_r.raw_ch3;
  assign raw_a[4] = item_r.raw_ch4;

  for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
    acd_lane u_lane (
      .clk        (clk),
      .raw        (raw_a[g]),
      .full_scale (fs_r[g]),
      .low_thr    (low_r),
      .high_thr   (high_r),
      .flags      (flags[g])
    );
  end

  acd_merge #(
    .CHANNELS (CHANNELS)
  ) u_merge (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmp_en          (state_r == S_CMP),
    .upd_en          (upd_go),
    .flags           (flags),
    .now_ms          (item_r.now_ms),
    .settle_ms       (settle_r),
    .ignore_extremes (item_r.ignore_extremes),
    .result          (result)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // A result appears only right after an update step.
  a_out_from_upd: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_UPD))
    else $error("result shown without an update step");

  // The active code is the smaller of the pair.
  a_active_le_mirror: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.active_code_out <= out_data_r.mirror_code_out))
    else $error("active code above mirror code");

  // Bits above the channel count never set.
  a_held_width: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_data_r.held_code_out >> CHANNELS) == '0))
    else $error("held code has bits beyond the channel count");

  // No new item is taken while one is in flight.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_MUL) && !in_ready)
    else $error("item accepted while another is in flight");
`endif

endmodule

FILE: design/acd_lane.sv
// One channel lane: decides whether the scaled percent of a sample falls at or
// below the low threshold or at or above the high one. Uses acd_pkg.
module acd_lane
  import acd_pkg::*;
(
  input  logic             clk,
  input  logic [RAW_W-1:0] raw,
  input  logic [RAW_W-1:0] full_scale,
  input  logic [THR_W-1:0] low_thr,
  input  logic [THR_W-1:0] high_thr,
  output lane_flags_t      flags
);

  // The percent is trunc((raw-20)*100/span). Instead of dividing, both
  // thresholds are multiplied by the span and compared with the numerator.
  logic [RAW_W-1:0]  fs_clamped;
  logic [RAW_W-1:0]  span;
  logic [RAW_W-1:0]  raw_off;
  logic              neg_nxt;
  logic [PROD_W-1:0] num_nxt;
  logic [PROD_W-1:0] lim_lo_nxt;
  logic [PROD_W-1:0] lim_hi_nxt;

  logic              neg_r;
  logic [PROD_W-1:0] num_r;
  logic [PROD_W-1:0] lim_lo_r;
  logic [PROD_W-1:0] lim_hi_r;
  lane_flags_t       flags_r;
  lane_flags_t       flags_nxt;

  always_comb begin
    fs_clamped = (full_scale < FS_MIN) ? FS_MIN : full_scale;
    span       = fs_clamped - FS_OFFSET;
    neg_nxt    = raw < FS_OFFSET;
    raw_off    = raw - FS_OFFSET;
    num_nxt    = PROD_W'(raw_off) * PROD_W'(PERCENT);
    lim_lo_nxt = (PROD_W'(low_thr) + PROD_W'(1)) * PROD_W'(span);
    lim_hi_nxt = PROD_W'(high_thr) * PROD_W'(span);
  end

  // A negative numerator gives a percent of zero or less, which always
  // clears, since the low threshold is never negative.
  always_comb begin
    flags_nxt.clr = neg_r || (num_r < lim_lo_r);
    flags_nxt.set = !neg_r && (num_r >= lim_hi_r);
  end

  always_ff @(posedge clk) begin
    neg_r    <= neg_nxt;
    num_r    <= num_nxt;
    lim_lo_r <= lim_lo_nxt;
    lim_hi_r <= lim_hi_nxt;
    flags_r  <= flags_nxt;
  end

  assign flags = flags_r;

endmodule

FILE: design/acd_merge.sv
// Merging stage: folds the lane flags into the held code, tracks settle time
// and updates the active and mirror codes. Uses acd_pkg.
module acd_merge
  import acd_pkg::*;
#(
  parameter int CHANNELS = DEF_CHANNELS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmp_en,
  input  logic                upd_en,
  input  lane_flags_t         flags [CHANNELS],
  input  logic [TIME_W-1:0]   now_ms,
  input  logic [SETTLE_W-1:0] settle_ms,
  input  logic                ignore_extremes,
  output out_item_t           result
);

  localparam logic [CODE_W-1:0] ALL_ONES = CODE_W'((1 << CHANNELS) - 1);

  logic [CODE_W-1:0] held_r,   held_nxt;
  logic [CODE_W-1:0] active_r, active_nxt;
  logic [CODE_W-1:0] mirror_r, mirror_nxt;
  logic [TIME_W-1:0] ct_r,     ct_nxt;
  logic              ok_old_r;

  logic [TIME_W-1:0] elapsed;
  logic [CODE_W-1:0] code;
  logic [CODE_W-1:0] rev;
  logic              code_chg;
  logic              time_ok;
  logic              take;

  // Elapsed time against the stored change time; its compare with the settle time is registered in the compare step.
  assign elapsed = now_ms - ct_r;

  always_comb begin
    code = '0;
    rev  = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (flags[i].clr) begin
        code[i] = 1'b0;
      end else if (flags[i].set) begin
        code[i] = 1'b1;
      end else begin
        code[i] = held_r[i];
      end
    end
    for (int i = 0; i < CHANNELS; i++) begin
      rev[CHANNELS-1-i] = code[i];
    end
    code_chg = code != held_r;
    // When the code just changed, the elapsed time is zero.
    time_ok  = code_chg ? (settle_ms == '0) : ok_old_r;
    take     = (code != active_r) && (code != mirror_r) && time_ok;

    held_nxt   = code;
    ct_nxt     = code_chg ? now_ms : ct_r;
    active_nxt = active_r;
    mirror_nxt = mirror_r;
    if (take) begin
      active_nxt = (code < rev) ? code : rev;
      mirror_nxt = (code < rev) ? rev : code;
    end

    result.changed         = take && (!ignore_extremes ||
                             (active_nxt != '0 && active_nxt != ALL_ONES));
    result.active_code_out = active_nxt;
    result.mirror_code_out = mirror_nxt;
    result.held_code_out   = held_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmp_en) begin
      ok_old_r <= elapsed >= TIME_W'(settle_ms);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r   <= '0;
      active_r <= '0;
      mirror_r <= '0;
      ct_r     <= '0;
    end else if (upd_en) begin
      held_r   <= held_nxt;
      active_r <= active_nxt;
      mirror_r <= mirror_nxt;
      ct_r     <= ct_nxt;
    end
  end

endmodule
